[hw/rtl/xxtea_block_cipher_64_core_assert.svh]
// Assertion macros used by the XXTEA core controller.
`ifndef XXTEA_BLOCK_CIPHER_64_CORE_ASSERT_SVH
`define XXTEA_BLOCK_CIPHER_64_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define XX_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xxtea: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define XX_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xxtea: next-cycle check failed");

`endif

[hw/rtl/xxtea_pkg.sv]
// Types and constants for the XXTEA 64-bit block core.
package xxtea_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned NUM_KEYS   = 4;
  localparam int unsigned KEY_IDX_W  = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned STEP_COUNT = 64;   // 32 rounds x 2 word updates
  localparam int unsigned CNT_W      = 6;

  localparam logic [WORD_W-1:0] DELTA         = 32'h9E37_79B9;
  localparam logic [WORD_W-1:0] SUM_DEC_START = 32'hC6EF_3720;  // 32*DELTA mod 2^32

  localparam logic [WORD_W-1:0] KEY0_RESET = 32'h0000_FDA5;
  localparam logic [WORD_W-1:0] KEY1_RESET = 32'h0000_D54E;
  localparam logic [WORD_W-1:0] KEY2_RESET = 32'h0000_FC00;
  localparam logic [WORD_W-1:0] KEY3_RESET = 32'h0000_B55A;

  // Operation codes on in_cmd
  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY3 = 3'd3;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } ctl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture a new block and command
    logic step;   // perform one word update
    logic half;   // second word update of the round
  } dp_cmd_t;

endpackage

[hw/rtl/xxtea_ctrl.sv]
// Sequencer for the XXTEA core: accepts a block, runs 64 word updates, strobes the result.
`include "xxtea_block_cipher_64_core_assert.svh"

module xxtea_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_valid,
  output xxtea_pkg::dp_cmd_t dp_cmd
);

  xxtea_pkg::ctl_state_t             state_r, state_nxt;
  logic [xxtea_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                              last_step;

  assign last_step = (cnt_r == xxtea_pkg::CNT_W'(xxtea_pkg::STEP_COUNT - 1));
  assign busy      = (state_r == xxtea_pkg::ST_RUN);
  assign out_valid = (state_r == xxtea_pkg::ST_DONE);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    dp_cmd.load = 1'b0;
    dp_cmd.step = 1'b0;
    dp_cmd.half = cnt_r[0];
    unique case (state_r)
      xxtea_pkg::ST_IDLE, xxtea_pkg::ST_DONE: begin
        // a new block may be taken in the cycle the previous result is shown
        if (start) begin
          dp_cmd.load = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = xxtea_pkg::ST_RUN;
        end else begin
          state_nxt   = xxtea_pkg::ST_IDLE;
        end
      end
      xxtea_pkg::ST_RUN: begin
        dp_cmd.step = 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (last_step) begin
          state_nxt = xxtea_pkg::ST_DONE;
        end
      end
      default: begin
        state_nxt = xxtea_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= xxtea_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `XX_ASSERT_NXT(a_last_step_strobes, busy && last_step, out_valid)
  `XX_ASSERT_NXT(a_accept_runs, start && !busy, busy && (cnt_r == '0))
  `XX_ASSERT_IMP(a_strobe_not_busy, out_valid, !busy)
  `XX_ASSERT_NXT(a_strobe_one_cycle, out_valid, !out_valid)
  `XX_ASSERT_IMP(a_no_load_while_busy, busy, !dp_cmd.load)

endmodule

[hw/rtl/xxtea_dp.sv]
// XXTEA datapath: key registers, block words, round sum and one shared mix unit.
module xxtea_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  xxtea_pkg::dp_cmd_t                 dp_cmd,
  input  logic                               in_cmd,
  input  logic [xxtea_pkg::WORD_W-1:0]       in_word_first,
  input  logic [xxtea_pkg::WORD_W-1:0]       in_word_second,
  input  logic                               cfg_we,
  input  logic [xxtea_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [xxtea_pkg::WORD_W-1:0]       cfg_wdata,
  output logic [xxtea_pkg::WORD_W-1:0]       out_first,
  output logic [xxtea_pkg::WORD_W-1:0]       out_second
);

  logic [xxtea_pkg::WORD_W-1:0] key_r [xxtea_pkg::NUM_KEYS];
  logic [xxtea_pkg::WORD_W-1:0] v0_r, v0_nxt;
  logic [xxtea_pkg::WORD_W-1:0] v1_r, v1_nxt;
  logic [xxtea_pkg::WORD_W-1:0] sum_r, sum_nxt;
  logic                         dec_r, dec_nxt;

  logic                           sel_p;     // 1: update v1 from v0, 0: update v0 from v1
  logic [xxtea_pkg::WORD_W-1:0]   src, dst, mix_a, mix_b, mix_c, mix_d, mix_v, dst_new;
  logic [xxtea_pkg::KEY_IDX_W-1:0] key_idx;

  // Key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r[0] <= xxtea_pkg::KEY0_RESET;
      key_r[1] <= xxtea_pkg::KEY1_RESET;
      key_r[2] <= xxtea_pkg::KEY2_RESET;
      key_r[3] <= xxtea_pkg::KEY3_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        xxtea_pkg::CFG_KEY0: key_r[0] <= cfg_wdata;
        xxtea_pkg::CFG_KEY1: key_r[1] <= cfg_wdata;
        xxtea_pkg::CFG_KEY2: key_r[2] <= cfg_wdata;
        xxtea_pkg::CFG_KEY3: key_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Mix unit, y == z for a two-word block
  assign sel_p   = dp_cmd.half ^ dec_r;
  assign src     = sel_p ? v0_r : v1_r;
  assign dst     = sel_p ? v1_r : v0_r;
  assign key_idx = {1'b0, sel_p} ^ sum_r[3:2];
  assign mix_a   = (src >> 5) ^ (src << 2);
  assign mix_b   = (src >> 3) ^ (src << 4);
  assign mix_c   = sum_r ^ src;
  assign mix_d   = key_r[key_idx] ^ src;
  assign mix_v   = (mix_a + mix_b) ^ (mix_c + mix_d);
  assign dst_new = dec_r ? (dst - mix_v) : (dst + mix_v);

  always_comb begin
    v0_nxt  = v0_r;
    v1_nxt  = v1_r;
    sum_nxt = sum_r;
    dec_nxt = dec_r;
    if (dp_cmd.load) begin
      v0_nxt  = in_word_first;
      v1_nxt  = in_word_second;
      dec_nxt = in_cmd;
      sum_nxt = (in_cmd == xxtea_pkg::CMD_DECRYPT) ? xxtea_pkg::SUM_DEC_START
                                                   : xxtea_pkg::DELTA;
    end else if (dp_cmd.step) begin
      if (sel_p) begin
        v1_nxt = dst_new;
      end else begin
        v0_nxt = dst_new;
      end
      // sum moves once per round, after its second update
      if (dp_cmd.half) begin
        sum_nxt = dec_r ? (sum_r - xxtea_pkg::DELTA) : (sum_r + xxtea_pkg::DELTA);
      end
    end
  end

  always_ff @(posedge clk) begin
    v0_r  <= v0_nxt;
    v1_r  <= v1_nxt;
    sum_r <= sum_nxt;
    dec_r <= dec_nxt;
  end

  assign out_first  = v0_r;
  assign out_second = v1_r;

endmodule

[hw/rtl/xxtea_block_cipher_64_core.sv]
// Top level of the XXTEA 64-bit block core: controller plus datapath.
// A block is accepted at a clock edge where start is high and busy is low. The core then
// runs its word updates, one per cycle through a single shared mix unit (32 rounds of
// two updates), and shows the result on out_first/out_second for exactly one cycle with
// out_valid high; the receiver cannot stall, so the result must be taken in that cycle.
// A new block may be started in the same cycle the result is shown; none is accepted
// while busy. The user must write the key through cfg_we/cfg_index/cfg_wdata only while
// idle, as the core itself does not enforce it; indexes above 3 are ignored.
module xxtea_block_cipher_64_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_cmd,
  input  logic [xxtea_pkg::WORD_W-1:0]    in_word_first,
  input  logic [xxtea_pkg::WORD_W-1:0]    in_word_second,
  output logic                            out_valid,
  output logic [xxtea_pkg::WORD_W-1:0]    out_first,
  output logic [xxtea_pkg::WORD_W-1:0]    out_second,
  input  logic                            cfg_we,
  input  logic [xxtea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [xxtea_pkg::WORD_W-1:0]    cfg_wdata
);

  xxtea_pkg::dp_cmd_t dp_cmd;

  xxtea_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .dp_cmd    (dp_cmd)
  );

  xxtea_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .dp_cmd         (dp_cmd),
    .in_cmd         (in_cmd),
    .in_word_first  (in_word_first),
    .in_word_second (in_word_second),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_first      (out_first),
    .out_second     (out_second)
  );

endmodule
